[hdl/bsk_pkg.sv]
// bsk_pkg: shared constants, write-select codes and command/status types
// for the bitonic key/value sorter. No dependencies.
package bsk_pkg;

    // default sizing of the sorter
    localparam int MAX_ITEMS_DEF = 64;
    localparam int KEY_BITS_DEF  = 64;

    // port widths fixed by the interface
    localparam int KEY_W     = 64;
    localparam int PAYLOAD_W = 32;
    localparam int LOG_W     = 3;

    // widest store address for the supported range of MAX_ITEMS
    localparam int ADDR_W_MAX = 6;

    // batch size register after reset
    localparam logic [LOG_W-1:0] LENGTH_LOG2_RST = 3'd6;

    // write data select codes
    localparam logic [1:0] WR_SEL_INPUT  = 2'd0;
    localparam logic [1:0] WR_SEL_B_TO_A = 2'd1;
    localparam logic [1:0] WR_SEL_A_TO_B = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic                  wr_en;
        logic [1:0]            wr_sel;
        logic [ADDR_W_MAX-1:0] wr_addr;
        logic                  rd_en;
        logic [ADDR_W_MAX-1:0] rd_addr_a;
        logic [ADDR_W_MAX-1:0] rd_addr_b;
        logic                  ascending;
    } bsk_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic swap;
    } bsk_status_t;

endpackage

[hdl/bsk_ram.sv]
// bsk_ram: generic RAM, one write port and two read ports with registered
// read data. No dependencies.
module bsk_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read ports
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

[hdl/bsk_datapath.sv]
// bsk_datapath: pair store, write data selection and key comparator.
// Depends on bsk_pkg and bsk_ram.
module bsk_datapath #(
    parameter int MAX_ITEMS = bsk_pkg::MAX_ITEMS_DEF,
    parameter int KEY_BITS  = bsk_pkg::KEY_BITS_DEF
) (
    input  logic                             clk,
    input  bsk_pkg::bsk_cmd_t                cmd,
    input  logic [KEY_BITS-1:0]              key_in,
    input  logic [bsk_pkg::PAYLOAD_W-1:0]    payload_in,
    output logic [KEY_BITS-1:0]              key_out,
    output logic [bsk_pkg::PAYLOAD_W-1:0]    payload_out,
    output bsk_pkg::bsk_status_t             status
);
    import bsk_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int DW = KEY_BITS + PAYLOAD_W;

    logic [DW-1:0]       wr_data;
    logic [DW-1:0]       rd_data_a;
    logic [DW-1:0]       rd_data_b;
    logic [KEY_BITS-1:0] key_a;
    logic [KEY_BITS-1:0] key_b;

    // write data source
    always_comb
    begin
        case (cmd.wr_sel)
            WR_SEL_INPUT:  wr_data = {key_in, payload_in};
            WR_SEL_B_TO_A: wr_data = rd_data_b;
            WR_SEL_A_TO_B: wr_data = rd_data_a;
            default:       wr_data = {key_in, payload_in};
        endcase
    end

    bsk_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .clk       (clk),
        .wr_en     (cmd.wr_en),
        .wr_addr   (cmd.wr_addr[AW-1:0]),
        .wr_data   (wr_data),
        .rd_en     (cmd.rd_en),
        .rd_addr_a (cmd.rd_addr_a[AW-1:0]),
        .rd_addr_b (cmd.rd_addr_b[AW-1:0]),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // compare-exchange decision, equal keys swap when ascending
    assign key_a = rd_data_a[DW-1:PAYLOAD_W];
    assign key_b = rd_data_b[DW-1:PAYLOAD_W];
    assign status.swap = cmd.ascending ? (key_a >= key_b) : (key_a < key_b);

    // read port a also feeds the result ports
    assign key_out     = key_a;
    assign payload_out = rd_data_a[PAYLOAD_W-1:0];

endmodule

[hdl/bsk_ctrl.sv]
// bsk_ctrl: load / sort / drain sequencer for the bitonic sorter.
// Depends on bsk_pkg.
module bsk_ctrl #(
    parameter int MAX_ITEMS = bsk_pkg::MAX_ITEMS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      cfg_we,
    input  logic [bsk_pkg::LOG_W-1:0] cfg_data,
    input  bsk_pkg::bsk_status_t      status,
    output bsk_pkg::bsk_cmd_t         cmd,
    output logic                      busy,
    output logic                      res_valid,
    output logic                      res_last
);
    import bsk_pkg::*;

    localparam int AW       = $clog2(MAX_ITEMS);
    localparam int CAP_LOG2 = $clog2(MAX_ITEMS + 1) - 1;
    localparam logic [LOG_W-1:0] CAP = LOG_W'(CAP_LOG2);

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_WB   = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]       state_reg,  state_next;
    logic [LOG_W-1:0] len_reg,    len_next;
    logic [AW-1:0]    fill_reg,   fill_next;
    logic [LOG_W-1:0] stage_reg,  stage_next;
    logic [LOG_W-1:0] inc_reg,    inc_next;
    logic [AW-1:0]    pair_reg,   pair_next;
    logic [AW-1:0]    out_reg,    out_next;
    logic             valid_reg,  valid_next;
    logic             last_reg,   last_next;

    logic [LOG_W-1:0] nlog;
    logic [AW:0]      n;
    logic [AW-1:0]    lo_mask;
    logic [AW-1:0]    idx_a;
    logic [AW-1:0]    idx_b;
    logic [AW-1:0]    dir_bits;
    logic             pair_last;
    logic             out_last;
    logic             load_last;

    // effective batch size, saturated to the store
    assign nlog = (len_reg > CAP) ? CAP : len_reg;
    assign n    = (AW + 1)'(1) << nlog;

    // pair index: insert a zero at bit inc of the pair counter
    assign lo_mask   = (AW'(1) << inc_reg) - AW'(1);
    assign idx_a     = ((pair_reg & ~lo_mask) << 1) | (pair_reg & lo_mask);
    assign idx_b     = idx_a | (AW'(1) << inc_reg);
    assign dir_bits  = idx_a >> (stage_reg + LOG_W'(1));
    assign pair_last = (pair_reg == AW'((n >> 1) - (AW + 1)'(1)));
    assign out_last  = ((AW + 1)'(out_reg) == n - (AW + 1)'(1));
    assign load_last = ((AW + 1)'(fill_reg) + (AW + 1)'(1) == n);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        fill_next  = fill_reg;
        stage_next = stage_reg;
        inc_next   = inc_reg;
        pair_next  = pair_reg;
        out_next   = out_reg;
        valid_next = 1'b0;
        last_next  = 1'b0;

        cmd           = '0;
        cmd.wr_sel    = WR_SEL_INPUT;
        cmd.ascending = (dir_bits[0] == 1'b0);
        cmd.rd_addr_a = ADDR_W_MAX'(idx_a);
        cmd.rd_addr_b = ADDR_W_MAX'(idx_b);

        case (state_reg)
            S_LOAD:
            begin
                if (start && !cfg_we)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_sel  = WR_SEL_INPUT;
                    cmd.wr_addr = ADDR_W_MAX'(fill_reg);
                    if (load_last)
                    begin
                        fill_next  = '0;
                        stage_next = '0;
                        inc_next   = '0;
                        pair_next  = '0;
                        out_next   = '0;
                        state_next = (nlog == '0) ? S_OUT : S_RD;
                    end
                    else
                    begin
                        fill_next = fill_reg + AW'(1);
                    end
                end
            end
            S_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                // lower slot takes the upper entry
                cmd.wr_en   = status.swap;
                cmd.wr_sel  = WR_SEL_B_TO_A;
                cmd.wr_addr = ADDR_W_MAX'(idx_a);
                state_next  = S_WB;
            end
            S_WB:
            begin
                // upper slot takes the lower entry, then step the network
                cmd.wr_en   = status.swap;
                cmd.wr_sel  = WR_SEL_A_TO_B;
                cmd.wr_addr = ADDR_W_MAX'(idx_b);
                state_next  = S_RD;
                if (pair_last)
                begin
                    pair_next = '0;
                    if (inc_reg == '0)
                    begin
                        if (stage_reg == nlog - LOG_W'(1))
                        begin
                            out_next   = '0;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            stage_next = stage_reg + LOG_W'(1);
                            inc_next   = stage_reg + LOG_W'(1);
                        end
                    end
                    else
                    begin
                        inc_next = inc_reg - LOG_W'(1);
                    end
                end
                else
                begin
                    pair_next = pair_reg + AW'(1);
                end
            end
            S_OUT:
            begin
                cmd.rd_en     = 1'b1;
                cmd.rd_addr_a = ADDR_W_MAX'(out_reg);
                valid_next    = 1'b1;
                last_next     = out_last;
                if (out_last)
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    out_next = out_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        // register write drops a partial batch
        if (cfg_we)
        begin
            len_next  = cfg_data;
            fill_next = '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            len_reg   <= LENGTH_LOG2_RST;
            fill_reg  <= '0;
            stage_reg <= '0;
            inc_reg   <= '0;
            pair_reg  <= '0;
            out_reg   <= '0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            fill_reg  <= fill_next;
            stage_reg <= stage_next;
            inc_reg   <= inc_next;
            pair_reg  <= pair_next;
            out_reg   <= out_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
    end

    assign busy      = (state_reg != S_LOAD);
    assign res_valid = valid_reg;
    assign res_last  = last_reg;

endmodule

[hdl/bitonic_sort_by_key_unit.sv]
// bitonic_sort_by_key_unit: one request loads a key/payload pair while busy is low.
// After the n-th pair the sorter runs; each compare-exchange through the two-read
// store is a read (S_RD), then writes of the lower (S_CMP) and upper (S_WB) slots.
// Results then stream one per cycle, each registered from a store read issued in
// S_OUT once the sort ends, and the receiver cannot stall.
// Async active-low reset clears control and sets length_log2 to 6; store not cleared.
module bitonic_sort_by_key_unit #(
    parameter int MAX_ITEMS = bsk_pkg::MAX_ITEMS_DEF,
    parameter int KEY_BITS  = bsk_pkg::KEY_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [bsk_pkg::KEY_W-1:0]     key,
    input  logic [bsk_pkg::PAYLOAD_W-1:0] payload,
    input  logic                          length_log2_we,
    input  logic [bsk_pkg::LOG_W-1:0]     length_log2_wdata,
    output logic                          result_valid,
    output logic [bsk_pkg::KEY_W-1:0]     sorted_key,
    output logic [bsk_pkg::PAYLOAD_W-1:0] sorted_payload,
    output logic                          last
);
    import bsk_pkg::*;

    bsk_cmd_t            cmd;
    bsk_status_t         status;
    logic [KEY_BITS-1:0] key_rd;

    // sequencer
    bsk_ctrl #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cfg_we    (length_log2_we),
        .cfg_data  (length_log2_wdata),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy),
        .res_valid (result_valid),
        .res_last  (last)
    );

    // store and comparator, keys cut to KEY_BITS on the way in
    bsk_datapath #(
        .MAX_ITEMS (MAX_ITEMS),
        .KEY_BITS  (KEY_BITS)
    ) u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .key_in      (key[KEY_BITS-1:0]),
        .payload_in  (payload),
        .key_out     (key_rd),
        .payload_out (sorted_payload),
        .status      (status)
    );

    assign sorted_key = KEY_W'(key_rd);

    // last only marks a result
    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> result_valid)
        else $error("last without result strobe");

    // a batch streams without gaps up to its last result
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |=> result_valid)
        else $error("gap inside result burst");

    // no new request is taken in the middle of a burst
    a_no_accept_mid_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |-> busy)
        else $error("request accepted during result burst");

    // the sorter only starts after an accepted request
    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without request");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking bench for bitonic_sort_by_key_unit; a scoreboard class re-sorts each
// loaded batch and checks the streamed results in order. Depends on bsk_pkg and the RTL.
module tb;
    import bsk_pkg::*;

    localparam int MAX_ITEMS     = MAX_ITEMS_DEF;
    localparam int KEY_BITS      = KEY_BITS_DEF;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 450;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 50;
    localparam logic [KEY_W-1:0] KEY_MASK =
        (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} : ((64'd1 << KEY_BITS) - 64'd1);

    // one sorted pair as it should leave the block
    typedef struct packed {
        logic [KEY_W-1:0]     key_v;
        logic [PAYLOAD_W-1:0] payload_v;
        logic                 last_v;
    } sorted_pair_t;

    // batch model: collects pairs, sorts on the last one, queues the ordered stream
    class batch_sorter_sb;
        logic [KEY_W-1:0]     key_mem [MAX_ITEMS];
        logic [PAYLOAD_W-1:0] payload_mem [MAX_ITEMS];
        int unsigned          fill;
        logic [LOG_W-1:0]     len_log2;
        sorted_pair_t         sorted_q [$];
        int unsigned          errors;
        int unsigned          loaded;
        int unsigned          batches;
        int unsigned          checked;

        function new();
            fill     = 0;
            len_log2 = LENGTH_LOG2_RST;
            errors   = 0;
            loaded   = 0;
            batches  = 0;
            checked  = 0;
        endfunction

        function int unsigned pending();
            return sorted_q.size();
        endfunction

        // register write drops any partial batch
        function void set_length(logic [LOG_W-1:0] v);
            len_log2 = v;
            fill     = 0;
        endfunction

        // batch size saturates at the store depth
        function int unsigned batch_len();
            int unsigned n;
            n = 1 << len_log2;
            while (n > MAX_ITEMS && n > 1)
                n = n >> 1;
            return n;
        endfunction

        // bitonic network, ascending overall; equal keys swap in ascending stages
        function void bitonic_order(int unsigned n);
            int unsigned          span;
            int unsigned          stride;
            int unsigned          j;
            logic                 asc;
            logic                 swap;
            logic [KEY_W-1:0]     tk;
            logic [PAYLOAD_W-1:0] tp;
            for (span = 1; span < n; span = span << 1) begin
                for (stride = span; stride > 0; stride = stride >> 1) begin
                    for (int unsigned i = 0; i < n; i++) begin
                        j = i + stride;
                        if ((i & stride) == 0 && j < n) begin
                            asc  = ((span << 1) & i) == 0;
                            swap = asc ? (key_mem[i] >= key_mem[j]) : (key_mem[i] < key_mem[j]);
                            if (swap) begin
                                tk             = key_mem[i];
                                key_mem[i]     = key_mem[j];
                                key_mem[j]     = tk;
                                tp             = payload_mem[i];
                                payload_mem[i] = payload_mem[j];
                                payload_mem[j] = tp;
                            end
                        end
                    end
                end
            end
        endfunction

        // accepted request: store the pair, emit the sorted batch when full
        function void note_request(logic [KEY_W-1:0] k, logic [PAYLOAD_W-1:0] p);
            int unsigned  n;
            sorted_pair_t e;
            n                 = batch_len();
            key_mem[fill]     = k & KEY_MASK;
            payload_mem[fill] = p;
            fill++;
            loaded++;
            if (fill >= n) begin
                bitonic_order(n);
                for (int unsigned i = 0; i < n; i++) begin
                    e.key_v     = key_mem[i];
                    e.payload_v = payload_mem[i];
                    e.last_v    = (i == n - 1);
                    sorted_q.push_back(e);
                end
                fill = 0;
                batches++;
            end
        endfunction

        function void flag(string what, logic [KEY_W-1:0] exp_v, logic [KEY_W-1:0] act_v);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h actual %h", $time, what, exp_v, act_v);
        endfunction

        // result strobe: compare against the oldest expected pair
        function void check_result(logic [KEY_W-1:0] k, logic [PAYLOAD_W-1:0] p, logic l);
            sorted_pair_t e;
            if (sorted_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none actual key %h payload %h last %b",
                             $time, k, p, l);
                return;
            end
            e = sorted_q.pop_front();
            checked++;
            if (k !== e.key_v)
                flag("sorted_key", e.key_v, k);
            if (p !== e.payload_v)
                flag("sorted_payload", KEY_W'(e.payload_v), KEY_W'(p));
            if (l !== e.last_v)
                flag("last", KEY_W'(e.last_v), KEY_W'(l));
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [KEY_W-1:0]     key = '0;
    logic [PAYLOAD_W-1:0] payload = '0;
    logic                 length_log2_we = 1'b0;
    logic [LOG_W-1:0]     length_log2_wdata = '0;
    logic                 result_valid;
    logic [KEY_W-1:0]     sorted_key;
    logic [PAYLOAD_W-1:0] sorted_payload;
    logic                 last;

    batch_sorter_sb sb;
    int unsigned    burst_left = 0;
    int unsigned    cycle_count = 0;
    logic [7:0]     used_lengths = '0;

    bitonic_sort_by_key_unit #(
        .MAX_ITEMS (MAX_ITEMS),
        .KEY_BITS  (KEY_BITS)
    ) u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .key               (key),
        .payload           (payload),
        .length_log2_we    (length_log2_we),
        .length_log2_wdata (length_log2_wdata),
        .result_valid      (result_valid),
        .sorted_key        (sorted_key),
        .sorted_payload    (sorted_payload),
        .last              (last)
    );

    always #5 clk = ~clk;

    // monitor: results first, then register writes and accepted requests
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                sb.check_result(sorted_key, sorted_payload, last);
            if (length_log2_we)
                sb.set_length(length_log2_wdata);
            else if (start && !busy)
                sb.note_request(key, payload);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // key mix: full random, small values for ties, 32-bit keys, extremes, close upper halves
    function automatic logic [KEY_W-1:0] rand_key();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return {$urandom, $urandom};
            4, 5:       return KEY_W'($urandom_range(0, 7));
            6:          return {32'h0, $urandom};
            7:
            begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return '1;
                    2:       return {1'b1, 63'h0};
                    default: return {1'b0, {63{1'b1}}};
                endcase
            end
            default:    return {30'h0, 2'($urandom_range(0, 3)), $urandom};
        endcase
    endfunction

    // one request, sent in bursts with random gaps; start stays high on return
    task automatic send_pair(input logic [KEY_W-1:0] k, input logic [PAYLOAD_W-1:0] p);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                start   <= 1'b0;
                key     <= {$urandom, $urandom};
                payload <= $urandom;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start   <= 1'b1;
        key     <= k;
        payload <= p;
        do @(posedge clk); while (busy);
    endtask

    // register write once the block has drained
    task automatic write_length(input logic [LOG_W-1:0] v);
        start <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0 || busy);
        repeat (SETTLE_CYCLES) @(posedge clk);
        length_log2_we    <= 1'b1;
        length_log2_wdata <= v;
        @(posedge clk);
        length_log2_we    <= 1'b0;
        used_lengths[v] = 1'b1;
    endtask

    initial
    begin
        int unsigned      random_sent;
        int unsigned      phase;
        int unsigned      n;
        int unsigned      nb;
        int unsigned      r;
        logic [LOG_W-1:0] v;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // batch of one: each pair comes straight back with last set
        write_length(3'd0);
        send_pair('0, '0);
        send_pair('1, '1);
        send_pair({1'b1, 63'h0}, 32'h5555_5555);

        // pairs: equal keys swap, reversed keys swap
        write_length(3'd1);
        send_pair(64'd42, 32'h0000_000A);
        send_pair(64'd42, 32'h0000_000B);
        send_pair('1, 32'h1);
        send_pair('0, 32'h2);

        // eight pairs with extremes and ties
        write_length(3'd3);
        send_pair('1, 32'h0);
        send_pair('0, 32'h1);
        send_pair(64'd5, 32'h2);
        send_pair(64'd5, 32'h3);
        send_pair(64'h0000_0001_0000_0000, 32'h4);
        send_pair(64'h0000_0000_FFFF_FFFF, 32'h5);
        send_pair('1, 32'hFFFF_FFFF);
        send_pair(64'd1, 32'hAAAA_AAAA);

        // partial batch dropped by a register write, then a full one
        write_length(3'd2);
        send_pair(64'd9, 32'h10);
        send_pair(64'd8, 32'h11);
        send_pair(64'd7, 32'h12);
        write_length(3'd2);
        send_pair(64'd3, 32'h20);
        send_pair(64'd1, 32'h21);
        send_pair(64'd2, 32'h22);
        send_pair(64'd0, 32'h23);

        // random phases: mostly small batches, one full-depth and one oversized setting
        random_sent = 0;
        phase       = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            if (phase == 2)
                v = 3'd6;
            else if (phase == 5)
                v = 3'd7;
            else
            begin
                r = $urandom_range(0, 15);
                v = (r < 2) ? 3'd0 : (r < 5) ? 3'd1 : (r < 8) ? 3'd2 :
                    (r < 12) ? 3'd3 : (r < 15) ? 3'd4 : 3'd5;
            end
            write_length(v);
            n = 1 << v;
            while (n > MAX_ITEMS)
                n = n >> 1;
            nb = (v >= 3'd5) ? 1 : $urandom_range(1, 4);
            for (int unsigned i = 0; i < nb * n; i++)
                send_pair(rand_key(), $urandom);
            random_sent += nb * n;
            // sometimes leave a partial batch for the next write to drop
            if (n > 1 && $urandom_range(0, 3) == 0)
            begin
                r = $urandom_range(1, n - 1);
                for (int unsigned i = 0; i < r; i++)
                    send_pair(rand_key(), $urandom);
                random_sent += r;
            end
            phase++;
        end

        // drain
        start <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (32) @(posedge clk);

        $display("loaded %0d pairs in %0d sorted batches, checked %0d results",
                 sb.loaded, sb.batches, sb.checked);
        $display("length_log2 settings used (bit per value): %b, errors %0d",
                 used_lengths, sb.errors);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[files.f]
hdl/bsk_pkg.sv
hdl/bsk_ram.sv
hdl/bsk_datapath.sv
hdl/bsk_ctrl.sv
hdl/bitonic_sort_by_key_unit.sv
tb/tb.sv
